// File: hdl/per_link_cusum_excursion_detector_unit_assert.svh
// Assertion macros shared by the detector RTL.
`ifndef PER_LINK_CUSUM_EXCURSION_DETECTOR_UNIT_ASSERT_SVH
`define PER_LINK_CUSUM_EXCURSION_DETECTOR_UNIT_ASSERT_SVH

// Checked at every clock edge outside reset.
`define PLCED_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define PLCED_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/plced_pkg.sv
// Shared types, constants and register codes of the per-link CUSUM detector.
`default_nettype none

package plced_pkg;

    localparam int TAG_COUNT_DEF    = 16;
    localparam int ANCHOR_COUNT_DEF = 16;

    // Number of codes the 4-bit key fields can carry.
    localparam int KEY_CODES = 16;

    localparam int SUM_W   = 24;
    localparam int STAMP_W = 32;
    localparam int COUNT_W = 16;
    localparam int Z_W     = 16;
    localparam int KAPPA_W = 16;
    localparam int OBS_W   = 32;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [KAPPA_W-1:0] KAPPA_RESET     = 16'd128;
    localparam logic [SUM_W-1:0]   THRESHOLD_RESET = 24'd1280;
    localparam logic [STAMP_W-1:0] GAP_LIMIT_RESET = 32'd1000;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_KAPPA     = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_GAP_LIMIT = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REVERSE = 1'b1;

    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_INVALID = 2'd1;
    localparam logic [1:0] REASON_GAP     = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0]   cusum_sum;
        logic [STAMP_W-1:0] last_valid_stamp;
        logic               has_valid_stamp;
        logic [STAMP_W-1:0] last_seen_stamp;
        logic               has_seen_stamp;
        logic [COUNT_W-1:0] excursion_count;
        logic               excursion_active;
        logic               alarm_set;
        logic [STAMP_W-1:0] excursion_begin;
    } t_link_state;

endpackage

`default_nettype wire

// File: hdl/per_link_cusum_excursion_detector_unit.sv
// Top level of the per-link one-sided CUSUM excursion detector.
//
//  channel   direction  handshake               payload
//  input     in         i_valid / o_stall       tag, anchor, time, z, row valid, obs id
//  result    out        o_valid / i_stall       status, reason, sums, excursion, flags
//  config    in         psel/penable/pready     APB, 32-bit data, byte address 4*index
//
// An observation reads its link entry from the state RAM at the transfer edge, is
// worked out in the next cycle and written back while its result enters the output
// register: one transfer per cycle sustained while the result side is not stalled.
// A row on the same link as the one just ahead takes the forwarded entry.
// After reset a clearing pass zeroes the RAM, one link per cycle, across all
// TAG_COUNT*ANCHOR_COUNT links; o_stall stays high meanwhile.
// A stalled result holds the working stage, which then stalls the input.
`default_nettype none
`include "per_link_cusum_excursion_detector_unit_assert.svh"

module per_link_cusum_excursion_detector_unit #(
    parameter int TAG_COUNT    = plced_pkg::TAG_COUNT_DEF,
    parameter int ANCHOR_COUNT = plced_pkg::ANCHOR_COUNT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [3:0]                          i_tag_id,
    input  wire logic [3:0]                          i_anchor_id,
    input  wire logic [plced_pkg::STAMP_W-1:0]       i_time_stamp,
    input  wire logic signed [plced_pkg::Z_W-1:0]    i_z_score,
    input  wire logic                                i_row_valid,
    input  wire logic [plced_pkg::OBS_W-1:0]         i_observation_id,

    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_status,
    output logic [1:0]                               o_clear_cause,
    output logic [plced_pkg::SUM_W-1:0]              o_sum_before,
    output logic [plced_pkg::SUM_W-1:0]              o_sum_after,
    output logic                                     o_excursion_open,
    output logic [plced_pkg::COUNT_W-1:0]            o_excursion_number,
    output logic [plced_pkg::STAMP_W-1:0]            o_excursion_start,
    output logic                                     o_alarm_edge,
    output logic                                     o_candidate,
    output logic [plced_pkg::OBS_W-1:0]              o_observation_echo,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [plced_pkg::APB_AW-1:0]        paddr,
    input  wire logic [plced_pkg::APB_DW-1:0]        pwdata,
    output logic [plced_pkg::APB_DW-1:0]             prdata,
    output logic                                     pready
);

    localparam int LINK_COUNT = TAG_COUNT * ANCHOR_COUNT;
    localparam int LINK_W     = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
    localparam int STATE_W    = $bits(plced_pkg::t_link_state);
    localparam int SUM_W      = plced_pkg::SUM_W;
    localparam int STAMP_W    = plced_pkg::STAMP_W;
    localparam int Z_W        = plced_pkg::Z_W;
    localparam int KAPPA_W    = plced_pkg::KAPPA_W;
    localparam int G_W        = SUM_W + 2;

    // Configuration registers.
    logic [KAPPA_W-1:0] r_kappa;
    logic [SUM_W-1:0]   r_threshold;
    logic [STAMP_W-1:0] r_gap_limit;
    logic               w_cfg_write;
    logic [1:0]         w_cfg_index;

    // Clearing pass.
    logic              r_clr_busy;
    logic [LINK_W-1:0] r_clr_addr;

    // Working stage.
    logic               r_s1_v;
    logic [LINK_W-1:0]  r_s1_link;
    logic [STAMP_W-1:0] r_s1_time;
    logic [Z_W-1:0]     r_s1_z;
    logic               r_s1_row_valid;
    logic [plced_pkg::OBS_W-1:0] r_s1_obs;
    logic               r_fwd_hit;
    plced_pkg::t_link_state r_fwd_state;

    // Output register.
    logic r_out_v;

    logic [LINK_W-1:0]  w_tag_base [plced_pkg::KEY_CODES];
    logic [LINK_W-1:0]  w_anc_off  [plced_pkg::KEY_CODES];
    logic [LINK_W-1:0]  w_link;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_s1_fire;
    logic [STATE_W-1:0] w_rdata;
    logic [STATE_W-1:0] w_wdata;
    logic [LINK_W-1:0]  w_waddr;
    logic               w_we;

    plced_pkg::t_link_state w_cur;
    plced_pkg::t_link_state n_state;
    logic               w_reject;
    logic               w_gap;
    logic [STAMP_W-1:0] w_dt;
    logic [SUM_W-1:0]   w_base;
    logic signed [G_W-1:0] w_g;
    logic [SUM_W-1:0]   w_clamped;
    logic               n_status;
    logic [1:0]         n_reason;
    logic [SUM_W-1:0]   n_before;
    logic               n_crossing;
    logic               n_candidate;

    // Key tables: the field codes folded into the configured link counts.
    for (genvar gi = 0; gi < plced_pkg::KEY_CODES; gi++) begin : g_key
        assign w_tag_base[gi] = LINK_W'((gi % TAG_COUNT) * ANCHOR_COUNT);
        assign w_anc_off[gi]  = LINK_W'(gi % ANCHOR_COUNT);
    end

    assign w_link = w_tag_base[i_tag_id] + w_anc_off[i_anchor_id];

    assign w_out_free = !r_out_v || !i_stall;
    assign w_s1_fire  = r_s1_v && w_out_free;
    assign o_stall    = r_clr_busy || (r_s1_v && !w_out_free);
    assign w_in_acc   = i_valid && !o_stall;

    // ---------------- configuration port ----------------
    assign pready      = 1'b1;
    assign w_cfg_index = paddr[3:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kappa     <= plced_pkg::KAPPA_RESET;
            r_threshold <= plced_pkg::THRESHOLD_RESET;
            r_gap_limit <= plced_pkg::GAP_LIMIT_RESET;
        end else if (w_cfg_write) begin
            unique case (w_cfg_index)
                plced_pkg::REG_KAPPA:     r_kappa     <= pwdata[KAPPA_W-1:0];
                plced_pkg::REG_THRESHOLD: r_threshold <= pwdata[SUM_W-1:0];
                plced_pkg::REG_GAP_LIMIT: r_gap_limit <= pwdata[STAMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_index)
            plced_pkg::REG_KAPPA:
                prdata = {{(plced_pkg::APB_DW-KAPPA_W){1'b0}}, r_kappa};
            plced_pkg::REG_THRESHOLD:
                prdata = {{(plced_pkg::APB_DW-SUM_W){1'b0}}, r_threshold};
            plced_pkg::REG_GAP_LIMIT:
                prdata = r_gap_limit;
            default:
                prdata = '0;
        endcase
    end

    // ---------------- clearing pass ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LINK_W'(LINK_COUNT - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---------------- state memory ----------------
    assign w_we    = r_clr_busy || w_s1_fire;
    assign w_waddr = r_clr_busy ? r_clr_addr : r_s1_link;
    assign w_wdata = r_clr_busy ? '0 : STATE_W'(n_state);

    plced_ram #(
        .WIDTH (STATE_W),
        .DEPTH (LINK_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_in_acc),
        .i_raddr (w_link),
        .o_rdata (w_rdata)
    );

    // ---------------- working stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_v <= 1'b1;
                // The RAM read at this edge misses the entry being written now.
                r_fwd_hit <= w_s1_fire && (w_link == r_s1_link);
            end else if (w_s1_fire) begin
                r_s1_v    <= 1'b0;
                r_fwd_hit <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_link      <= w_link;
            r_s1_time      <= i_time_stamp;
            r_s1_z         <= i_z_score;
            r_s1_row_valid <= i_row_valid;
            r_s1_obs       <= i_observation_id;
        end
        if (w_s1_fire) begin
            r_fwd_state <= n_state;
        end
    end

    assign w_cur = r_fwd_hit ? r_fwd_state : plced_pkg::t_link_state'(w_rdata);

    assign w_reject = w_cur.has_seen_stamp && (r_s1_time < w_cur.last_seen_stamp);
    assign w_dt     = r_s1_time - w_cur.last_valid_stamp;
    assign w_gap    = w_cur.has_valid_stamp && (r_s1_time >= w_cur.last_valid_stamp)
                      && (w_dt > r_gap_limit);
    assign w_base   = w_gap ? '0 : w_cur.cusum_sum;

    assign w_g = $signed({2'b00, w_base})
               + $signed({{(G_W-Z_W){r_s1_z[Z_W-1]}}, r_s1_z})
               - $signed({{(G_W-KAPPA_W){1'b0}}, r_kappa});

    always_comb begin
        if (w_g[G_W-1]) begin
            w_clamped = '0;
        end else if (|w_g[G_W-2:SUM_W]) begin
            w_clamped = plced_pkg::SUM_MAX;
        end else begin
            w_clamped = w_g[SUM_W-1:0];
        end
    end

    always_comb begin
        n_state     = w_cur;
        n_status    = plced_pkg::STATUS_OK;
        n_reason    = plced_pkg::REASON_NONE;
        n_before    = w_cur.cusum_sum;
        n_crossing  = 1'b0;
        n_candidate = 1'b0;
        if (w_reject) begin
            n_status = plced_pkg::STATUS_REVERSE;
        end else begin
            n_state.has_seen_stamp  = 1'b1;
            n_state.last_seen_stamp = r_s1_time;
            if (!r_s1_row_valid) begin
                n_reason                 = plced_pkg::REASON_INVALID;
                n_state.cusum_sum        = '0;
                n_state.has_valid_stamp  = 1'b0;
                n_state.excursion_active = 1'b0;
                n_state.alarm_set        = 1'b0;
                n_state.excursion_begin  = '0;
            end else begin
                if (w_gap) begin
                    n_reason                 = plced_pkg::REASON_GAP;
                    n_state.excursion_active = 1'b0;
                    n_state.alarm_set        = 1'b0;
                    n_state.excursion_begin  = '0;
                end
                n_before                 = w_base;
                n_state.cusum_sum        = w_clamped;
                n_state.has_valid_stamp  = 1'b1;
                n_state.last_valid_stamp = r_s1_time;
                if (w_clamped != '0) begin
                    if (!n_state.excursion_active) begin
                        n_state.excursion_active = 1'b1;
                        n_state.excursion_count  = n_state.excursion_count + 1'b1;
                        n_state.excursion_begin  = r_s1_time;
                    end
                    if (!n_state.alarm_set && (w_clamped >= r_threshold)) begin
                        n_state.alarm_set = 1'b1;
                        n_crossing        = 1'b1;
                    end
                    n_candidate = n_state.alarm_set;
                end else begin
                    n_state.excursion_active = 1'b0;
                    n_state.alarm_set        = 1'b0;
                    n_state.excursion_begin  = '0;
                end
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_s1_fire) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            o_status           <= n_status;
            o_clear_cause      <= n_reason;
            o_sum_before       <= n_before;
            o_sum_after        <= n_state.cusum_sum;
            o_excursion_open   <= n_state.excursion_active;
            o_excursion_number <= n_state.excursion_count;
            o_excursion_start  <= n_state.excursion_active ? n_state.excursion_begin : '0;
            o_alarm_edge       <= n_crossing;
            o_candidate        <= n_candidate;
            o_observation_echo <= r_s1_obs;
        end
    end

    assign o_valid = r_out_v;

    // ---------------- assertions ----------------
    `PLCED_ASSERT_RUN(a_s1_holds, (r_s1_v && !w_s1_fire) |=> (r_s1_v && $stable(r_s1_link)),
        "working stage lost its row while the result side was stalled")
    `PLCED_ASSERT_RUN(a_fwd_needs_row, r_fwd_hit |-> r_s1_v,
        "forwarding selected with no row in the working stage")
    `PLCED_ASSERT_RUN(a_clear_alone, r_clr_busy |-> (!r_s1_v && !w_in_acc),
        "row taken while the state memory is being cleared")
    `PLCED_ASSERT_RUN(a_crossing_alarmed,
        (o_valid && o_alarm_edge) |-> (o_candidate && o_excursion_open),
        "threshold crossing reported outside an alarmed excursion")
    `PLCED_ASSERT_RUN(a_reject_quiet,
        (o_valid && o_status) |->
            ((o_clear_cause == plced_pkg::REASON_NONE) && (o_sum_before == o_sum_after)
             && !o_alarm_edge && !o_candidate),
        "rejected row reported a state change")

endmodule

`default_nettype wire

// File: hdl/plced_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module plced_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
